// ----- rtl/core/bbr_pkg.sv -----
`timescale 1ns / 1ps

package bbr_pkg;

   // sample and geometry widths
   localparam int CHAN_W = 8;
   localparam int NUM_CHAN = 3;
   localparam int ROWS_W = 13;
   localparam int COLS_W = 11;
   // raster position of a centre pixel, wide enough for rows * cols
   localparam int OUT_W = ROWS_W + COLS_W;

   // configuration port
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 1'd1;

   // result queue depth, covers the pipeline latency at full rate
   localparam int FIFO_DEPTH = 8;

   // one pixel, channel 0 in the low byte
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_type;

   // per-item control carried from the input stage into the window
   typedef struct packed {
      logic       valid;
      logic       emit;
      logic       frame_end;
      logic [2:0] col_ok;
      logic [2:0] row_ok;
   } win_ctrl_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // one result word
   typedef struct packed {
      logic      frame_end;
      pixel_type blur;
   } result_type;

endpackage

// ----- rtl/core/bbr_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bbr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bbr_pkg::OUT_W-1:0]    dividend,
   input  logic [bbr_pkg::COLS_W-1:0]   divisor,
   output bbr_pkg::div_status_type      status,
   output logic [bbr_pkg::OUT_W-1:0]    quot,
   output logic [bbr_pkg::COLS_W-1:0]   rem
);

   localparam int CNT_W = $clog2(bbr_pkg::OUT_W + 1);
   localparam logic [CNT_W-1:0] STEPS = CNT_W'(bbr_pkg::OUT_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [bbr_pkg::OUT_W-1:0]   quo_ff, quo_in;
   logic [bbr_pkg::COLS_W-1:0]  rem_ff, rem_in;
   logic [bbr_pkg::COLS_W-1:0]  div_ff, div_in;
   logic [bbr_pkg::COLS_W:0]    trial;
   logic                        ge;

   // one shift and trial subtract
   always_comb begin
      trial = {rem_ff, quo_ff[bbr_pkg::OUT_W-1]};
      ge = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = STEPS;
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[bbr_pkg::OUT_W-2:0], ge};
         rem_in = ge ? bbr_pkg::COLS_W'(trial - {1'b0, div_ff})
                     : trial[bbr_pkg::COLS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff || done_ff;
   assign status.done = done_ff;
   assign quot = quo_ff;
   assign rem = rem_ff;

endmodule

// ----- rtl/core/bbr_line.sv -----
`timescale 1ns / 1ps

// two line stores in one memory word; read in the accept cycle,
// written back in the cycle after with the row shifted up
module bbr_line #(
   parameter int MAX_COLS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  logic [$clog2(MAX_COLS)-1:0] push_addr,
   input  bbr_pkg::pixel_type          push_pix,
   output logic                        clearing,
   output bbr_pkg::pixel_type          upper,
   output bbr_pkg::pixel_type          middle,
   output bbr_pkg::pixel_type          cur
);

   localparam int ADDR_W = $clog2(MAX_COLS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_COLS - 1);

   typedef struct packed {
      bbr_pkg::pixel_type upper;
      bbr_pkg::pixel_type middle;
   } line_word_type;

   line_word_type       mem [MAX_COLS];
   line_word_type       rd_ff;
   line_word_type       last_ff;
   line_word_type       old_word;
   line_word_type       wr_data;
   logic [ADDR_W-1:0]   wr_addr;
   logic                wr_en;
   logic                b_valid_ff;
   logic [ADDR_W-1:0]   b_addr_ff;
   bbr_pkg::pixel_type  b_pix_ff;
   logic                fwd_ff, fwd_in;
   logic                clear_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;

   // back-to-back items on one column see the word just written
   assign fwd_in = push_valid && b_valid_ff && (push_addr == b_addr_ff);
   assign old_word = fwd_ff ? last_ff : rd_ff;

   // write port: clearing pass or row shift
   always_comb begin
      wr_en = clear_ff || b_valid_ff;
      wr_addr = clear_ff ? clr_addr_ff : b_addr_ff;
      wr_data = '0;
      if (!clear_ff) begin
         wr_data.upper = old_word.middle;
         wr_data.middle = b_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (push_valid) begin
         rd_ff <= mem[push_addr];
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         b_valid_ff <= push_valid;
         fwd_ff <= fwd_in;
      end
      b_addr_ff <= push_addr;
      b_pix_ff <= push_pix;
      if (b_valid_ff) begin
         last_ff <= wr_data;
      end
   end

   assign clearing = clear_ff;
   assign upper = old_word.upper;
   assign middle = old_word.middle;
   assign cur = b_pix_ff;

endmodule

// ----- rtl/core/bbr_win.sv -----
`timescale 1ns / 1ps

// 3x3 window, masked sum and divide by nine
module bbr_win (
   input  logic                   clock,
   input  logic                   reset,
   input  bbr_pkg::win_ctrl_type  ctrl,
   input  bbr_pkg::pixel_type     upper,
   input  bbr_pkg::pixel_type     middle,
   input  bbr_pkg::pixel_type     cur,
   output logic                   push,
   output bbr_pkg::result_type    result
);

   localparam int SUM_W = 12;
   localparam int MUL_W = 13;
   localparam int PROD_W = SUM_W + MUL_W;
   // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
   localparam logic [MUL_W-1:0] DIV9_MUL = 13'd7282;
   localparam int DIV9_SHIFT = 16;

   // [column][row], column 0 oldest (left), row 0 upper
   bbr_pkg::pixel_type   win_ff [3][3];
   logic                 c_emit_ff;
   logic                 c_fe_ff;
   logic [2:0]           c_col_ok_ff;
   logic [2:0]           c_row_ok_ff;
   logic [SUM_W-1:0]     sum_in [bbr_pkg::NUM_CHAN];
   logic [SUM_W-1:0]     sum_ff [bbr_pkg::NUM_CHAN];
   logic                 d_emit_ff;
   logic                 d_fe_ff;
   logic [PROD_W-1:0]    prod [bbr_pkg::NUM_CHAN];

   // window shift, one column per item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[j][i] <= '0;
            end
         end
      end else if (ctrl.valid) begin
         for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[j][i] <= win_ff[j+1][i];
            end
         end
         win_ff[2][0] <= upper;
         win_ff[2][1] <= middle;
         win_ff[2][2] <= cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_emit_ff <= 1'b0;
         d_emit_ff <= 1'b0;
      end else begin
         c_emit_ff <= ctrl.valid && ctrl.emit;
         d_emit_ff <= c_emit_ff;
      end
      c_fe_ff <= ctrl.frame_end;
      c_col_ok_ff <= ctrl.col_ok;
      c_row_ok_ff <= ctrl.row_ok;
      d_fe_ff <= c_fe_ff;
      sum_ff <= sum_in;
   end

   // sum of the neighbours inside the frame
   always_comb begin
      for (int ch = 0; ch < bbr_pkg::NUM_CHAN; ch++) begin
         sum_in[ch] = '0;
         for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
               if (c_col_ok_ff[j] && c_row_ok_ff[i]) begin
                  sum_in[ch] = sum_in[ch] + SUM_W'(win_ff[j][i][ch]);
               end
            end
         end
      end
   end

   // divide by nine through the reciprocal
   always_comb begin
      for (int ch = 0; ch < bbr_pkg::NUM_CHAN; ch++) begin
         prod[ch] = PROD_W'(sum_ff[ch]) * PROD_W'(DIV9_MUL);
         result.blur[ch] = prod[ch][DIV9_SHIFT +: bbr_pkg::CHAN_W];
      end
      result.frame_end = d_fe_ff;
   end

   assign push = d_emit_ff;

endmodule

// ----- rtl/core/bbr_fifo.sv -----
`timescale 1ns / 1ps

// result queue ahead of the output handshake
module bbr_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bbr_pkg::result_type  push_word,
   input  logic                 pop,
   output logic                 not_empty,
   output bbr_pkg::result_type  head
);

   localparam int PTR_W = $clog2(bbr_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(bbr_pkg::FIFO_DEPTH + 1);

   bbr_pkg::result_type  mem [bbr_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   assign not_empty = cnt_ff != '0;
   assign head = mem[rd_ptr_ff];

endmodule

// ----- rtl/core/box_blur_3x3_rgb_core.sv -----
`timescale 1ns / 1ps

// Streaming 3x3 box blur of an RGB frame. Pixels enter in raster order, one
// word per clock while req_ready is high, followed by frame_cols+1 flush
// words; each centre pixel comes out as the floor of its window sum over
// nine, neighbours outside the frame counting as zero, with frame_end on the
// last one. Sustained rate is one word per clock while the result queue has
// room: the line stores are a single memory read in the accept cycle and
// written back the next, and the accepted word, the window and the window
// sum are registered in turn, with the divide by nine combinational on the
// sum as it enters the output queue. After reset the line store is cleared,
// and after any configuration write the input is held off while a serial
// divider, one bit per clock, maps the output position onto the new geometry.
module box_blur_3x3_rgb_core #(
   parameter int MAX_COLS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [bbr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_chan_0,
   input  logic [7:0]                       req_chan_1,
   input  logic [7:0]                       req_chan_2,
   input  logic                             req_flush,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_blur_0,
   output logic [7:0]                       rsp_blur_1,
   output logic [7:0]                       rsp_blur_2,
   output logic                             rsp_frame_end
);

   localparam int ADDR_W = $clog2(MAX_COLS);
   localparam int COLS_W = bbr_pkg::COLS_W;
   localparam int ROWS_W = bbr_pkg::ROWS_W;
   localparam int OUT_W = bbr_pkg::OUT_W;
   localparam int CLAMP = (MAX_COLS > 2047) ? 2047 : MAX_COLS;
   localparam logic [COLS_W-1:0] COLS_MAX = COLS_W'(CLAMP);
   localparam int PEND_W = $clog2(bbr_pkg::FIFO_DEPTH + 1);
   localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(bbr_pkg::FIFO_DEPTH);

   // how many rows of the frame have started
   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   function automatic logic [1:0] ph_inc(input logic [1:0] ph);
      logic [1:0] r;
      r = (ph == PH_FIRST) ? PH_SECOND : PH_BODY;
      return r;
   endfunction

   logic [ROWS_W-1:0]           rows_ff;
   logic [COLS_W-1:0]           cols_ff;
   logic [OUT_W-1:0]            total_ff;
   logic                        cfg_wr_ff;
   logic [COLS_W-1:0]           in_col_ff, in_col_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [OUT_W-1:0]            out_cnt_ff, out_cnt_in;
   logic [OUT_W-1:0]            cr_ff, cr_in;
   logic [COLS_W-1:0]           cc_ff, cc_in;
   logic [PEND_W-1:0]           pend_ff;
   bbr_pkg::win_ctrl_type       a_ctrl_ff, a_ctrl_in;

   logic                        accept;
   logic                        pop;
   logic                        wrap0;
   logic                        wrap1;
   logic [COLS_W-1:0]           col_w;
   logic [COLS_W-1:0]           col_nx;
   logic [COLS_W:0]             cc_nx;
   logic [1:0]                  ph_w;
   logic                        emit;
   logic                        frame_end;
   logic [OUT_W:0]              cnt_nx;
   logic [OUT_W:0]              cr_nx;
   logic [2:0]                  col_ok;
   logic [2:0]                  row_ok;
   bbr_pkg::pixel_type          in_pix;

   bbr_pkg::div_status_type     div_st;
   logic [OUT_W-1:0]            div_quot;
   logic [COLS_W-1:0]           div_rem;
   logic                        clearing;
   bbr_pkg::pixel_type          ln_upper;
   bbr_pkg::pixel_type          ln_middle;
   bbr_pkg::pixel_type          ln_cur;
   logic                        res_push;
   bbr_pkg::result_type         res_word;
   bbr_pkg::result_type         head;

   // configuration registers, stored with zero and oversize mapped
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_W'(1);
         cols_ff <= COLS_W'(1);
         cfg_wr_ff <= 1'b0;
      end else begin
         cfg_wr_ff <= csr_write_en;
         if (csr_write_en) begin
            unique case (csr_index)
               bbr_pkg::CSR_FRAME_ROWS: begin
                  rows_ff <= (csr_wdata == '0) ? ROWS_W'(1) : csr_wdata;
               end
               bbr_pkg::CSR_FRAME_COLS: begin
                  if (csr_wdata[COLS_W-1:0] == '0) begin
                     cols_ff <= COLS_W'(1);
                  end else if (csr_wdata[COLS_W-1:0] > COLS_MAX) begin
                     cols_ff <= COLS_MAX;
                  end else begin
                     cols_ff <= csr_wdata[COLS_W-1:0];
                  end
               end
            endcase
         end
      end
      total_ff <= OUT_W'(rows_ff) * OUT_W'(cols_ff);
   end

   // output position after a geometry change
   bbr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cfg_wr_ff),
      .dividend (out_cnt_ff),
      .divisor  (cols_ff),
      .status   (div_st),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign pop = rsp_valid && rsp_ready;
   assign req_ready = !csr_write_en && !cfg_wr_ff && !div_st.busy && !clearing
                      && (pend_ff < PEND_MAX);
   assign accept = req_valid && req_ready;
   assign in_pix = req_flush ? '0 : {req_chan_2, req_chan_1, req_chan_0};

   // input position, emit decision and neighbour mask
   always_comb begin
      wrap0 = in_col_ff >= cols_ff;
      col_w = wrap0 ? '0 : in_col_ff;
      ph_w = wrap0 ? ph_inc(phase_ff) : phase_ff;
      col_nx = col_w + 1'b1;
      wrap1 = col_nx >= cols_ff;
      emit = (ph_w == PH_BODY) || ((ph_w == PH_SECOND) && (col_w != '0));
      cnt_nx = {1'b0, out_cnt_ff} + 1'b1;
      frame_end = emit && (cnt_nx >= {1'b0, total_ff});
      cc_nx = {1'b0, cc_ff} + 1'b1;
      cr_nx = {1'b0, cr_ff} + 1'b1;

      col_ok[0] = cc_ff != '0;
      col_ok[1] = 1'b1;
      col_ok[2] = cc_nx < {1'b0, cols_ff};
      row_ok[0] = (cr_ff != '0) && (cr_ff <= OUT_W'(rows_ff));
      row_ok[1] = cr_ff < OUT_W'(rows_ff);
      row_ok[2] = cr_nx < (OUT_W + 1)'(rows_ff);

      in_col_in = in_col_ff;
      phase_in = phase_ff;
      out_cnt_in = out_cnt_ff;
      cr_in = cr_ff;
      cc_in = cc_ff;
      if (div_st.done) begin
         cr_in = div_quot;
         cc_in = div_rem;
      end
      if (accept) begin
         in_col_in = wrap1 ? '0 : col_nx;
         phase_in = wrap1 ? ph_inc(ph_w) : ph_w;
         if (emit) begin
            out_cnt_in = cnt_nx[OUT_W-1:0];
            if (cc_nx == {1'b0, cols_ff}) begin
               cc_in = '0;
               cr_in = cr_nx[OUT_W-1:0];
            end else begin
               cc_in = cc_nx[COLS_W-1:0];
            end
         end
         if (frame_end) begin
            in_col_in = '0;
            phase_in = PH_FIRST;
            out_cnt_in = '0;
            cr_in = '0;
            cc_in = '0;
         end
      end

      a_ctrl_in.valid = accept;
      a_ctrl_in.emit = emit;
      a_ctrl_in.frame_end = frame_end;
      a_ctrl_in.col_ok = col_ok;
      a_ctrl_in.row_ok = row_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         phase_ff <= PH_FIRST;
         out_cnt_ff <= '0;
         cr_ff <= '0;
         cc_ff <= '0;
         pend_ff <= '0;
         a_ctrl_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         phase_ff <= phase_in;
         out_cnt_ff <= out_cnt_in;
         cr_ff <= cr_in;
         cc_ff <= cc_in;
         pend_ff <= pend_ff + PEND_W'(accept && emit) - PEND_W'(pop);
         a_ctrl_ff <= a_ctrl_in;
      end
   end

   bbr_line #(
      .MAX_COLS (MAX_COLS)
   ) u_line (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push_addr  (ADDR_W'(col_w)),
      .push_pix   (in_pix),
      .clearing   (clearing),
      .upper      (ln_upper),
      .middle     (ln_middle),
      .cur        (ln_cur)
   );

   bbr_win u_win (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (a_ctrl_ff),
      .upper  (ln_upper),
      .middle (ln_middle),
      .cur    (ln_cur),
      .push   (res_push),
      .result (res_word)
   );

   bbr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_word (res_word),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_blur_0 = head.blur[0];
   assign rsp_blur_1 = head.blur[1];
   assign rsp_blur_2 = head.blur[2];
   assign rsp_frame_end = head.frame_end;

endmodule

// ----- rtl/core/bbr_chk.sv -----
`timescale 1ns / 1ps

// port-level checks
module bbr_chk (
   input logic       clock,
   input logic       reset,
   input logic       csr_write_en,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_blur_0,
   input logic [7:0] rsp_blur_1,
   input logic [7:0] rsp_blur_2,
   input logic       rsp_frame_end
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blur_0)
         && $stable(rsp_blur_1) && $stable(rsp_blur_2) && $stable(rsp_frame_end))
      else $error("result word changed while stalled");

   // line store clearing and empty queue right after reset
   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("block active right after reset");

   // no input word taken during a configuration write
   a_cfg_same: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |-> !req_ready)
      else $error("input taken during configuration write");

   // input also held off right after a configuration write
   a_cfg_next: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !req_ready)
      else $error("input taken right after configuration write");

endmodule

bind box_blur_3x3_rgb_core bbr_chk u_chk (
   .clock         (clock),
   .reset         (reset),
   .csr_write_en  (csr_write_en),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_blur_0    (rsp_blur_0),
   .rsp_blur_1    (rsp_blur_1),
   .rsp_blur_2    (rsp_blur_2),
   .rsp_frame_end (rsp_frame_end)
);
